// ===== design/hdrtm_pkg.sv =====
// Shared types and constants of the HDR tone map and gamma pixel pipeline.
package hdrtm_pkg;

  localparam int unsigned FRAC_BITS_DEF     = 16;
  localparam int unsigned GAMMA_ENTRIES_DEF = 1024;

  localparam int unsigned SUM_W      = 32;
  localparam int unsigned OUT_W      = 24;
  localparam int unsigned SPP_W      = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RECIP_W    = 33;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  typedef enum logic [0:0] {
    CFG_SAMPLES = 1'b0,
    CFG_TONE_EN = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] blue_sum;
  } pix_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
  } pix_out_t;

  // Status of the reciprocal unit toward the datapath.
  typedef struct packed {
    logic               busy;
    logic [RECIP_W-1:0] value;
  } recip_t;

endpackage

// ===== design/hdr_tonemap_gamma_pixel_top.sv =====
// Top level of the HDR tone map and gamma pixel pipeline.
// One pixel per clock: each beat carries three Q16.16 radiance sums, each is
// scaled by the reciprocal of samples_per_pixel, then either passed out
// saturated (tone_map_enable = 0) or sent through the ACES filmic curve and a
// gamma 1/2.2 table with linear interpolation. The divider of the curve makes
// one quotient bit per stage. The pipeline advances whenever the output register
// is empty or taken, so a beat enters every cycle while the output flows.
// A write to samples_per_pixel starts a bit-serial reciprocal divider that runs
// until it has made its last quotient bit; hold input beats off (in_stall_o
// stays high) for that time.
// Write configuration only with the pipeline empty.
module hdr_tonemap_gamma_pixel_top #(
  parameter int unsigned FRACTION_BITS       = hdrtm_pkg::FRAC_BITS_DEF,
  parameter int unsigned GAMMA_TABLE_ENTRIES = hdrtm_pkg::GAMMA_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  hdrtm_pkg::pix_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output hdrtm_pkg::pix_out_t              out_data_o,
  input  logic                             cfg_we_i,
  input  hdrtm_pkg::cfg_reg_e              cfg_idx_i,
  input  logic [hdrtm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import hdrtm_pkg::*;

  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned LAT = F + 7;

  recip_t           recip;
  logic             tone_q;
  logic             adv;
  logic             in_acc;
  logic [LAT-1:0]   vld_q;

  logic [F:0]       t_r, t_g, t_b;
  logic [OUT_W-1:0] lin_r, lin_g, lin_b;
  logic [OUT_W-1:0] res_r, res_g, res_b;

  // Advance every stage together; the last stage is the output register.
  assign adv         = !vld_q[LAT-1] || !out_stall_i;
  assign in_stall_o  = !adv || recip.busy;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_acc};
    end
  end

  // Mode register; the sample count lives in the reciprocal unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_q <= 1'b1;
    end else if (cfg_we_i && (cfg_idx_i == CFG_TONE_EN)) begin
      tone_q <= cfg_wdata_i[0];
    end
  end

  hdrtm_recip u_recip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .recip_o     (recip)
  );

  // Scale and curve, one lane per color.
  hdrtm_aces #(.FRACTION_BITS(F)) u_aces_r (
    .clk_i (clk_i), .en_i (adv), .recip_i (recip.value),
    .sum_i (in_data_i.red_sum), .t_o (t_r), .lin_o (lin_r)
  );
  hdrtm_aces #(.FRACTION_BITS(F)) u_aces_g (
    .clk_i (clk_i), .en_i (adv), .recip_i (recip.value),
    .sum_i (in_data_i.green_sum), .t_o (t_g), .lin_o (lin_g)
  );
  hdrtm_aces #(.FRACTION_BITS(F)) u_aces_b (
    .clk_i (clk_i), .en_i (adv), .recip_i (recip.value),
    .sum_i (in_data_i.blue_sum), .t_o (t_b), .lin_o (lin_b)
  );

  // Gamma and output select.
  hdrtm_gamma #(.FRACTION_BITS(F), .GAMMA_TABLE_ENTRIES(GAMMA_TABLE_ENTRIES)) u_gamma_r (
    .clk_i (clk_i), .en_i (adv), .tone_en_i (tone_q),
    .t_i (t_r), .lin_i (lin_r), .out_o (res_r)
  );
  hdrtm_gamma #(.FRACTION_BITS(F), .GAMMA_TABLE_ENTRIES(GAMMA_TABLE_ENTRIES)) u_gamma_g (
    .clk_i (clk_i), .en_i (adv), .tone_en_i (tone_q),
    .t_i (t_g), .lin_i (lin_g), .out_o (res_g)
  );
  hdrtm_gamma #(.FRACTION_BITS(F), .GAMMA_TABLE_ENTRIES(GAMMA_TABLE_ENTRIES)) u_gamma_b (
    .clk_i (clk_i), .en_i (adv), .tone_en_i (tone_q),
    .t_i (t_b), .lin_i (lin_b), .out_o (res_b)
  );

  assign out_data_o = '{red_out: res_r, green_out: res_g, blue_out: res_b};

endmodule

// ===== design/hdrtm_recip.sv =====
// Sample count register and bit-serial reciprocal divider.
module hdrtm_recip (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  hdrtm_pkg::cfg_reg_e                 cfg_idx_i,
  input  logic [hdrtm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output hdrtm_pkg::recip_t                   recip_o
);
  import hdrtm_pkg::*;

  localparam int unsigned QW = SUM_W;
  localparam int unsigned CW = $clog2(QW);

  logic               busy_q;
  logic [CW-1:0]      cnt_q;
  logic [RECIP_W-1:0] recip_q;
  logic [SPP_W-1:0]   div_q;
  logic [SPP_W-1:0]   rem_q;
  logic [QW-1:0]      quo_q;

  logic               start;
  logic [SPP_W:0]     trial;
  logic               ge;
  logic [QW-1:0]      quo_d;
  logic [SPP_W-1:0]   rem_d;

  assign start = cfg_we_i && (cfg_idx_i == CFG_SAMPLES);

  // ceil(2^32 / n) = floor((2^32 - 1) / n) + 1; dividend bits are all ones
  assign trial = {rem_q, 1'b1};
  assign ge    = trial >= {1'b0, div_q};
  assign rem_d = ge ? SPP_W'(trial - {1'b0, div_q}) : trial[SPP_W-1:0];
  assign quo_d = {quo_q[QW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      recip_q <= RECIP_W'(1) << SUM_W;
    end else if (start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(QW - 1)) begin
        busy_q  <= 1'b0;
        recip_q <= RECIP_W'(quo_d) + RECIP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      div_q <= (cfg_wdata_i[SPP_W-1:0] == '0) ? SPP_W'(1) : cfg_wdata_i[SPP_W-1:0];
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign recip_o = '{busy: busy_q, value: recip_q};

endmodule

// ===== design/hdrtm_aces.sv =====
// Per-channel scaling and ACES curve with a pipelined restoring divider.
module hdrtm_aces #(
  parameter int unsigned FRACTION_BITS = hdrtm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [hdrtm_pkg::RECIP_W-1:0]     recip_i,
  input  logic [hdrtm_pkg::SUM_W-1:0]       sum_i,
  output logic [FRACTION_BITS:0]            t_o,
  output logic [hdrtm_pkg::OUT_W-1:0]       lin_o
);
  import hdrtm_pkg::*;

  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned WS = F + 3;
  localparam int unsigned WA = F + 11;
  localparam int unsigned WP = 2 * F + 14;

  // stage 1: scale by reciprocal
  logic [SUM_W-1:0] prod_hi_q;
  logic [SUM_W-1:0] sum1_q;
  logic             pass1_q;
  logic [2*SUM_W-1:0] prod;

  assign prod = (2*SUM_W)'(sum_i) * (2*SUM_W)'(recip_i[SUM_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_hi_q <= prod[2*SUM_W-1:SUM_W];
      sum1_q    <= sum_i;
      pass1_q   <= recip_i[SUM_W];
    end
  end

  // stage 2: curve coefficients
  logic [SUM_W-1:0] s;
  logic [WS-1:0]    s_lo;
  logic [WA-1:0]    a, b;
  logic             big;
  logic [OUT_W-1:0] lin;
  logic [WS-1:0]    s2_q;
  logic [WA-1:0]    a2_q, b2_q;
  logic             big2_q;
  logic [OUT_W-1:0] lin2_q;

  // a reciprocal of exactly one has a zero low word, so the product is zero and the sum passes unscaled
  assign s    = pass1_q ? sum1_q : prod_hi_q;
  assign s_lo = s[WS-1:0];
  assign big  = |s[SUM_W-1:WS];
  assign lin  = (|s[SUM_W-1:OUT_W]) ? OUT_MAX : s[OUT_W-1:0];
  assign a    = WA'(s_lo) * WA'(251) + (WA'(3) << F);
  assign b    = WA'(s_lo) * WA'(243) + (WA'(59) << F);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q   <= s_lo;
      a2_q   <= a;
      b2_q   <= b;
      big2_q <= big;
      lin2_q <= lin;
    end
  end

  // stage 3: numerator and denominator
  logic [WP-1:0]    n3_q, d3_q;
  logic             big3_q;
  logic [OUT_W-1:0] lin3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n3_q   <= WP'(s2_q) * WP'(a2_q);
      d3_q   <= WP'(s2_q) * WP'(b2_q) + (WP'(14) << (2 * F));
      big3_q <= big2_q;
      lin3_q <= lin2_q;
    end
  end

  // F divider stages, one quotient bit each
  logic [WP-1:0]    r_in   [0:F-1];
  logic [WP-1:0]    d_in   [0:F-1];
  logic [F-1:0]     q_in   [0:F-1];
  logic             one_in [0:F-1];
  logic [OUT_W-1:0] lin_in [0:F-1];

  logic [WP-1:0]    r_q    [0:F-2];
  logic [WP-1:0]    d_q    [0:F-2];
  logic [F-1:0]     q_q    [0:F-1];
  logic             one_q  [0:F-1];
  logic [OUT_W-1:0] lin_q  [0:F-1];

  for (genvar k = 0; k < F; k++) begin : g_div
    logic [WP:0] rs;
    logic        ge;

    if (k == 0) begin : g_first
      assign r_in[k]   = n3_q;
      assign d_in[k]   = d3_q;
      assign q_in[k]   = '0;
      assign one_in[k] = big3_q || (n3_q >= d3_q);
      assign lin_in[k] = lin3_q;
    end else begin : g_next
      assign r_in[k]   = r_q[k-1];
      assign d_in[k]   = d_q[k-1];
      assign q_in[k]   = q_q[k-1];
      assign one_in[k] = one_q[k-1];
      assign lin_in[k] = lin_q[k-1];
    end

    assign rs = {r_in[k], 1'b0};
    assign ge = rs >= {1'b0, d_in[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k]   <= {q_in[k][F-2:0], ge};
        one_q[k] <= one_in[k];
        lin_q[k] <= lin_in[k];
      end
    end

    if (k < F - 1) begin : g_mid
      logic [WP-1:0] rn;
      assign rn = ge ? WP'(rs - {1'b0, d_in[k]}) : rs[WP-1:0];
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k] <= rn;
          d_q[k] <= d_in[k];
        end
      end
    end
  end

  assign t_o   = one_q[F-1] ? {1'b1, {F{1'b0}}} : {1'b0, q_q[F-1]};
  assign lin_o = lin_q[F-1];

endmodule

// ===== design/hdrtm_gamma.sv =====
// Per-channel gamma 1/2.2 through an interpolated constant table.
module hdrtm_gamma #(
  parameter int unsigned FRACTION_BITS       = hdrtm_pkg::FRAC_BITS_DEF,
  parameter int unsigned GAMMA_TABLE_ENTRIES = hdrtm_pkg::GAMMA_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          tone_en_i,
  input  logic [FRACTION_BITS:0]        t_i,
  input  logic [hdrtm_pkg::OUT_W-1:0]   lin_i,
  output logic [hdrtm_pkg::OUT_W-1:0]   out_o
);
  import hdrtm_pkg::*;

  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned M  = GAMMA_TABLE_ENTRIES;
  localparam int unsigned IW = $clog2(M + 1);
  localparam int unsigned PW = F + IW + 1;
  localparam int unsigned GW = 32;
  localparam int unsigned VW = GW + 1;

  typedef logic [GW-1:0] gtab_t [0:GAMMA_TABLE_ENTRIES];

  function automatic logic [63:0] q31_pow(logic [63:0] v, int unsigned k);
    logic [63:0] p;
    p = v;
    for (int unsigned n = 1; n < k; n++) begin
      p = (p * v) >> 31;
    end
    return p;
  endfunction

  // entry i: largest y with y^11 <= u^5 in Q1.31, u = i / M
  function automatic gtab_t build_gtab();
    gtab_t       tab;
    logic [63:0] u, tgt, lo, hi, mid;
    for (int unsigned i = 0; i <= GAMMA_TABLE_ENTRIES; i++) begin
      u   = (64'(i) << 31) / 64'(GAMMA_TABLE_ENTRIES);
      tgt = q31_pow(u, 5);
      lo  = '0;
      hi  = 64'h8000_0000;
      while (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (q31_pow(mid, 11) <= tgt) lo = mid;
        else hi = mid - 64'd1;
      end
      tab[i] = lo[GW-1:0];
    end
    return tab;
  endfunction

  localparam gtab_t GTAB = build_gtab();

  // G1: table position
  logic [PW-1:0]    p;
  logic [IW-1:0]    idx;
  logic             full;
  logic [IW-1:0]    ia1_q, ib1_q;
  logic [F-1:0]     frac1_q;
  logic [OUT_W-1:0] lin1_q;

  assign p    = PW'(t_i) * PW'(M);
  assign idx  = p[F +: IW];
  assign full = idx >= IW'(M);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ia1_q   <= full ? IW'(M) : idx;
      ib1_q   <= full ? IW'(M) : idx + IW'(1);
      frac1_q <= p[F-1:0];
      lin1_q  <= lin_i;
    end
  end

  // G2: table read, both neighbors
  logic [GW-1:0]    g0_q, g1_q;
  logic [F-1:0]     frac2_q;
  logic [OUT_W-1:0] lin2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g0_q    <= GTAB[ia1_q];
      g1_q    <= GTAB[ib1_q];
      frac2_q <= frac1_q;
      lin2_q  <= lin1_q;
    end
  end

  // G3: interpolation product
  logic [GW-1:0]   diff;
  logic [GW+F-1:0] prod;
  logic [GW-1:0]   ph3_q, g03_q;
  logic [OUT_W-1:0] lin3_q;

  assign diff = g1_q - g0_q;
  assign prod = (GW+F)'(diff) * (GW+F)'(frac2_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph3_q  <= prod[F +: GW];
      g03_q  <= g0_q;
      lin3_q <= lin2_q;
    end
  end

  // G4: round to output format, saturate, select mode
  logic [VW-1:0]    v, o;
  logic [OUT_W-1:0] gam;
  logic [OUT_W-1:0] out_q;

  assign v   = VW'(g03_q) + VW'(ph3_q);
  assign o   = (v + (VW'(1) << (30 - F))) >> (31 - F);
  assign gam = (|o[VW-1:OUT_W]) ? OUT_MAX : o[OUT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= tone_en_i ? gam : lin3_q;
    end
  end

  assign out_o = out_q;

endmodule

// ===== design/hdrtm_chk.sv =====
// Port-level checker for the pixel pipeline, bound to the top level.
module hdrtm_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input hdrtm_pkg::pix_out_t              out_data_o,
  input logic                             cfg_we_i,
  input hdrtm_pkg::cfg_reg_e              cfg_idx_i
);
  import hdrtm_pkg::*;

  // Hold a stalled output beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // A sample count write starts the divider, which holds off input.
  a_div_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == CFG_SAMPLES) |=> in_stall_o)
    else $error("input taken while reciprocal is computed");

  // With the output empty, input stall only comes from a sample count write.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) && !out_valid_o |-> $past(cfg_we_i && (cfg_idx_i == CFG_SAMPLES)))
    else $error("input stalled with no cause");

endmodule

bind hdr_tonemap_gamma_pixel_top hdrtm_chk u_hdrtm_chk (.*);
